/* hdl/lfu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_pkg
// shared constants and types for the lfu cache table
// ----------------------------------------------------------------------------
package lfu_pkg;

	localparam int unsigned SLOTS_DEF = 16;

	typedef enum logic [2:0] {
		CMD_PUT    = 3'd0,
		CMD_GET    = 3'd1,
		CMD_EVICT  = 3'd2,
		CMD_TOPK   = 3'd3,
		CMD_RESIZE = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_MISS    = 2'd1,
		ST_EMPTY   = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_APPLY,
		S_EVICT,
		S_LIST,
		S_DONE
	} fsm_t;

endpackage

/* hdl/lfu_cache_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_cache_table
// key-value store with least-frequently-used replacement; state in one memory
// per field, scanned one slot a cycle
// ----------------------------------------------------------------------------
// channel   direction  signals
// request   in         start, busy, cmd, lookup_key, data_word, amount
// result    out        strobe, status, out_key, out_value, occupancy,
//                      limit_now, last
// a scan of the slot memory reads one slot a cycle, with registered read data;
// put and get: scan, apply, done, then the result; evict n and resize with m
// victims: each victim gets a scan and then the evict state; top k: each entry
// gets a scan and then a listed result; other requests and empty listings go to done
// reset clears the valid bits, the occupancy count and sets the limit to SLOTS
// busy drops in the cycle of the last result strobe; results cannot be stalled
module lfu_cache_table
	import lfu_pkg::*;
#(
	parameter int unsigned SLOTS = SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  cmd,
	input  logic [31:0] lookup_key,
	input  logic [31:0] data_word,
	input  logic [4:0]  amount,
	output logic        strobe,
	output logic [1:0]  status,
	output logic [31:0] out_key,
	output logic [31:0] out_value,
	output logic [4:0]  occupancy,
	output logic [4:0]  limit_now,
	output logic        last
);

	localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int unsigned CW = $clog2(SLOTS + 1);
	localparam logic [IW:0] LAST_IDX = (IW + 1)'(SLOTS - 1);

	// slot memories
	logic [31:0] key_mem  [SLOTS];
	logic [31:0] val_mem  [SLOTS];
	logic [31:0] freq_mem [SLOTS];
	logic [SLOTS-1:0] valid_q;
	logic [SLOTS-1:0] taken_q;

	fsm_t        state_q, state_d;
	logic [2:0]  cmd_q;
	logic [31:0] key_q, data_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] occ_q;
	logic [CW-1:0] limit_q;

	// scan
	logic [IW:0]   rd_idx_q;
	logic          rd_v_s1;
	logic [IW-1:0] idx_s1;
	logic [31:0]   rk_s1, rv_s1, rf_s1;

	logic          best_v_q;
	logic [IW-1:0] best_q;
	logic [31:0]   best_v_val_q, best_f_q, best_k_q;
	logic          hit_q;
	logic [IW-1:0] hit_idx_q;
	logic [31:0]   hit_val_q, hit_f_q;
	logic          free_v_q;
	logic [IW-1:0] free_q;

	logic          out_v_q, out_last_q;
	logic [1:0]    out_st_q;
	logic [31:0]   out_k_q, out_val_q;

	logic scan_done;
	assign scan_done = !rd_v_s1 && (rd_idx_q > LAST_IDX);

	// compare of the slot just read against the current best
	logic cand_ok, cand_better;
	always_comb begin
		cand_ok = rd_v_s1 && valid_q[idx_s1] && !taken_q[idx_s1];
		if (cmd_q == CMD_TOPK)
			cand_better = !best_v_q || rf_s1 > best_f_q ||
				(rf_s1 == best_f_q && rv_s1 < best_v_val_q);
		else
			cand_better = !best_v_q || rf_s1 < best_f_q ||
				(rf_s1 == best_f_q && rv_s1 > best_v_val_q);
	end

	logic [CW-1:0] amt_c, eff_n;
	always_comb begin
		amt_c = (amount > 5'(SLOTS)) ? CW'(SLOTS) : CW'(amount);
		eff_n = (amt_c < occ_q) ? amt_c : occ_q;
	end

	// a put at the limit drops the victim, then fills the lowest free slot
	logic             put_evict;
	logic [IW-1:0]    put_idx;
	logic [SLOTS-1:0] put_oh, best_oh;
	always_comb begin
		put_evict = (occ_q >= limit_q) && best_v_q;
		if (put_evict && !(free_v_q && free_q < best_q))
			put_idx = best_q;
		else
			put_idx = free_q;
		put_oh  = SLOTS'(1) << put_idx;
		best_oh = SLOTS'(1) << best_q;
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SCAN && rd_idx_q <= LAST_IDX) begin
			idx_s1  <= rd_idx_q[IW-1:0];
			rk_s1   <= key_mem[rd_idx_q[IW-1:0]];
			rv_s1   <= val_mem[rd_idx_q[IW-1:0]];
			rf_s1   <= freq_mem[rd_idx_q[IW-1:0]];
		end
		if (state_q == S_APPLY && cmd_q == CMD_PUT) begin
			if (hit_q) begin
				val_mem[hit_idx_q]  <= data_q;
				freq_mem[hit_idx_q] <= (hit_f_q == '1) ? hit_f_q : hit_f_q + 32'd1;
			end else if (put_evict || free_v_q) begin
				key_mem[put_idx]  <= key_q;
				val_mem[put_idx]  <= data_q;
				freq_mem[put_idx] <= 32'd1;
			end
		end
		if (state_q == S_APPLY && cmd_q == CMD_GET && hit_q)
			freq_mem[hit_idx_q] <= (hit_f_q == '1) ? hit_f_q : hit_f_q + 32'd1;
		if (state_q == S_IDLE && start) begin
			key_q <= lookup_key;
			data_q <= data_word;
		end
		if (cand_ok && cand_better) begin
			best_v_val_q <= rv_s1;
			best_f_q     <= rf_s1;
			best_k_q     <= rk_s1;
			best_q       <= idx_s1;
		end
		if (cand_ok && rk_s1 == key_q) begin
			hit_idx_q <= idx_s1;
			hit_val_q <= rv_s1;
			hit_f_q   <= rf_s1;
		end
		if (rd_v_s1 && !valid_q[idx_s1] && !free_v_q)
			free_q <= idx_s1;
		if (state_q == S_APPLY) begin
			out_st_q  <= (cmd_q == CMD_GET && !hit_q) ? ST_MISS : ST_OK;
			out_k_q   <= '0;
			out_val_q <= (cmd_q == CMD_GET && hit_q) ? hit_val_q : '0;
		end else if (state_q == S_LIST) begin
			out_st_q  <= ST_OK;
			out_k_q   <= best_k_q;
			out_val_q <= best_v_val_q;
		end else if (state_q == S_IDLE && start) begin
			out_st_q  <= (cmd == CMD_TOPK && eff_n == '0) ? ST_EMPTY : ST_OK;
			out_k_q   <= '0;
			out_val_q <= '0;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (cmd)
						CMD_PUT, CMD_GET: state_d = S_SCAN;
						CMD_EVICT: state_d = (eff_n == '0) ? S_DONE : S_SCAN;
						CMD_TOPK: state_d = (eff_n == '0) ? S_DONE : S_SCAN;
						CMD_RESIZE: state_d = (occ_q > amt_c) ? S_SCAN : S_DONE;
						default: state_d = S_DONE;
					endcase
				end
			end
			S_SCAN: if (scan_done) begin
				if (cmd_q == CMD_PUT || cmd_q == CMD_GET)
					state_d = S_APPLY;
				else if (cmd_q == CMD_TOPK)
					state_d = S_LIST;
				else
					state_d = S_EVICT;
			end
			S_APPLY: state_d = S_DONE;
			S_EVICT: begin
				if (cmd_q == CMD_EVICT)
					state_d = (count_q == CW'(1)) ? S_DONE : S_SCAN;
				else
					state_d = (occ_q - CW'(1) > limit_q) ? S_SCAN : S_DONE;
			end
			S_LIST: state_d = (count_q == CW'(1)) ? S_IDLE : S_SCAN;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			valid_q  <= '0;
			taken_q  <= '0;
			occ_q    <= '0;
			limit_q  <= CW'(SLOTS);
			cmd_q    <= CMD_PUT;
			count_q  <= '0;
			rd_idx_q <= '0;
			rd_v_s1  <= 1'b0;
			best_v_q <= 1'b0;
			hit_q    <= 1'b0;
			free_v_q <= 1'b0;
			out_v_q  <= 1'b0;
			out_last_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= (state_q == S_SCAN && rd_idx_q <= LAST_IDX);
			out_v_q <= (state_q == S_DONE || state_q == S_LIST);
			out_last_q <= (state_q == S_DONE) || (state_q == S_LIST && count_q == CW'(1));
			if (state_q == S_IDLE && start) begin
				cmd_q    <= cmd;
				count_q  <= eff_n;
				taken_q  <= '0;
				rd_idx_q <= '0;
				best_v_q <= 1'b0;
				hit_q    <= 1'b0;
				free_v_q <= 1'b0;
				if (cmd == CMD_RESIZE)
					limit_q <= amt_c;
			end else begin
				if (state_q == S_SCAN && rd_idx_q <= LAST_IDX)
					rd_idx_q <= rd_idx_q + (IW + 1)'(1);
				else if ((state_q == S_EVICT || state_q == S_LIST) && state_d == S_SCAN)
					rd_idx_q <= '0;
				if ((state_q == S_EVICT || state_q == S_LIST) && state_d == S_SCAN)
					best_v_q <= 1'b0;
				else if (cand_ok && cand_better)
					best_v_q <= 1'b1;
				if (cand_ok && rk_s1 == key_q)
					hit_q <= 1'b1;
				if (rd_v_s1 && !valid_q[idx_s1])
					free_v_q <= 1'b1;
				if (state_q == S_APPLY && cmd_q == CMD_PUT && !hit_q) begin
					if (put_evict) begin
						valid_q <= (valid_q & ~best_oh) | put_oh;
					end else if (free_v_q) begin
						valid_q <= valid_q | put_oh;
						occ_q <= occ_q + CW'(1);
					end
				end
				if (state_q == S_EVICT) begin
					valid_q[best_q] <= 1'b0;
					occ_q <= occ_q - CW'(1);
					count_q <= count_q - CW'(1);
				end
				if (state_q == S_LIST) begin
					taken_q[best_q] <= 1'b1;
					count_q <= count_q - CW'(1);
				end
			end
		end
	end

	assign busy      = (state_q != S_IDLE);
	assign strobe    = out_v_q;
	assign status    = out_st_q;
	assign out_key   = out_k_q;
	assign out_value = out_val_q;
	assign occupancy = 5'(occ_q);
	assign limit_now = 5'(limit_q);
	assign last      = out_last_q;

	a_occ_le_slots: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CW'(SLOTS)) else $error("occupancy above slot count");
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy) else $error("non-final result while idle");
	a_occ_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(occ_q)) else $error("occupancy count mismatch");

endmodule
